// File: design/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared constants, types and helpers of the periodic task timer scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int MAX_OUT   = 16;
  localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int FIRE_W    = $clog2(MAX_OUT + 1);
  localparam int TIME_W    = 48;
  localparam int IVAL_W    = 32;

  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_TOG  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_ANN  = 2'd3;

  localparam logic [2:0] RK_REGISTERED = 3'd0;
  localparam logic [2:0] RK_TOGGLED    = 3'd1;
  localparam logic [2:0] RK_FIRED      = 3'd2;
  localparam logic [2:0] RK_REPORT     = 3'd3;
  localparam logic [2:0] RK_IDLE       = 3'd4;
  localparam logic [2:0] RK_REJECTED   = 3'd5;

  typedef logic [2:0] emit_sel_t;
  localparam emit_sel_t EM_REJ  = 3'd0;
  localparam emit_sel_t EM_REG  = 3'd1;
  localparam emit_sel_t EM_TOG  = 3'd2;
  localparam emit_sel_t EM_IDLE = 3'd3;
  localparam emit_sel_t EM_REP  = 3'd4;
  localparam emit_sel_t EM_PEND = 3'd5;

  typedef struct packed {
    logic      load;
    logic      tick_start;
    logic      ann_start;
    logic      ann_step;
    logic      scan_start;
    logic      scan_run;
    logic      reg_write;
    logic      tog_write;
    logic      fire_a;
    logic      fire_b;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } ptts_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic tog_bad;
    logic cnt_zero;
    logic ann_last;
    logic scan_done;
    logic found;
    logic pend_valid;
    logic fire_full;
  } ptts_stat_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// File: design/ptts_req_if.sv
// ----------------------------------------------------------------------------
// ptts_req_if
// Request channel: one beat per scheduler item.
// ----------------------------------------------------------------------------
interface ptts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] interval_ms;
  logic        start_on;
  logic [3:0]  task_id;
  logic [47:0] now_ms;

  modport source (output valid, kind, interval_ms, start_on, task_id, now_ms,
                  input ready);
  modport sink   (input valid, kind, interval_ms, start_on, task_id, now_ms,
                  output ready);
endinterface

// File: design/ptts_rsp_if.sv
// ----------------------------------------------------------------------------
// ptts_rsp_if
// Response channel: one beat per scheduler result.
// ----------------------------------------------------------------------------
interface ptts_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [3:0] task_number;
  logic       enabled;
  logic       call_periodic;
  logic       last;

  modport source (output valid, result_kind, task_number, enabled, call_periodic, last,
                  input ready);
  modport sink   (input valid, result_kind, task_number, enabled, call_periodic, last,
                  output ready);
endinterface

// File: design/ptts_ram.sv
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/ptts_dp.sv
// ----------------------------------------------------------------------------
// ptts_dp
// Datapath: task tables, deadline scan, deadline update and result register.
// ----------------------------------------------------------------------------
module ptts_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ptts_pkg::ptts_cmd_t  cmd,
  output ptts_pkg::ptts_stat_t stat,
  input  logic [31:0]          interval_ms,
  input  logic                 start_on,
  input  logic [3:0]           task_id,
  input  logic [47:0]          now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           result_kind,
  output logic [3:0]           task_number,
  output logic                 enabled,
  output logic                 call_periodic,
  output logic                 last
);
  localparam int TW = ptts_pkg::TASK_W;
  localparam int CW = ptts_pkg::CNT_W;
  localparam int FW = ptts_pkg::FIRE_W;
  localparam int NT = ptts_pkg::MAX_TASKS;

  // latched item
  logic [ptts_pkg::IVAL_W-1:0] ival;
  logic                        on;
  logic [3:0]                  id;
  logic [ptts_pkg::TIME_W-1:0] now;

  logic [CW-1:0]               count;
  logic [NT-1:0]               en;
  logic [NT-1:0]               done;

  logic [CW-1:0]               issue;
  logic                        cmp_valid;
  logic [TW-1:0]               cmp_idx;
  logic                        found;
  logic [TW-1:0]               best;
  logic [ptts_pkg::TIME_W-1:0] best_dl;
  logic [ptts_pkg::TIME_W-1:0] nx1;
  logic [ptts_pkg::TIME_W-1:0] alt;
  logic [FW-1:0]               fired;
  logic                        pend_valid;
  logic [3:0]                  pend_num;
  logic                        pend_en;
  logic [TW-1:0]               ann_idx;

  logic [ptts_pkg::IVAL_W-1:0] ival_c;
  logic [TW-1:0]               id_idx;
  logic [TW-1:0]               cnt_idx;
  logic [TW-1:0]               en_ridx;
  logic                        en_rd;
  logic [ptts_pkg::TIME_W-1:0] nx;
  logic [ptts_pkg::TIME_W-1:0] dl_wdata;
  logic [TW-1:0]               dl_waddr;
  logic                        dl_we;
  logic [ptts_pkg::TIME_W-1:0] dl_rdata;
  logic [ptts_pkg::IVAL_W-1:0] iv_rdata;
  logic [31:0]                 ann_end;
  logic [2:0]                  o_kind;
  logic [3:0]                  o_num;
  logic                        o_en;
  logic                        o_call;

  assign ival_c  = (ival == '0) ? ptts_pkg::IVAL_W'(1) : ival;
  assign id_idx  = TW'(id);
  assign cnt_idx = count[TW-1:0];
  assign nx      = (nx1 <= now) ? alt : nx1;
  assign ann_end = (32'(count) > 32'(ptts_pkg::MAX_OUT)) ? 32'(ptts_pkg::MAX_OUT)
                                                          : 32'(count);

  assign dl_we    = cmd.reg_write | cmd.fire_b;
  assign dl_waddr = cmd.reg_write ? cnt_idx : best;
  assign dl_wdata = cmd.reg_write ? ptts_pkg::sat_add(now, ptts_pkg::TIME_W'(ival_c)) : nx;

  ptts_ram #(.WIDTH(ptts_pkg::TIME_W), .DEPTH(NT)) u_deadline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (issue[TW-1:0]),
    .rdata (dl_rdata)
  );

  ptts_ram #(.WIDTH(ptts_pkg::IVAL_W), .DEPTH(NT)) u_interval (
    .clk   (clk),
    .we    (cmd.reg_write),
    .waddr (cnt_idx),
    .wdata (ival_c),
    .raddr (best),
    .rdata (iv_rdata)
  );

  // single read port on the enable bits
  always_comb begin
    case (cmd.emit_sel)
      ptts_pkg::EM_TOG: en_ridx = id_idx;
      ptts_pkg::EM_REP: en_ridx = ann_idx;
      default:          en_ridx = best;
    endcase
  end
  assign en_rd = en[en_ridx];

  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.full       = (32'(count) >= 32'(NT));
    stat.tog_bad    = (32'(id) >= 32'(count)) || (32'(id) >= 32'(NT));
    stat.cnt_zero   = (count == '0);
    stat.ann_last   = (32'(ann_idx) + 32'd1 == ann_end);
    stat.scan_done  = (issue == count) && !cmp_valid;
    stat.found      = found;
    stat.pend_valid = pend_valid;
    stat.fire_full  = (fired == FW'(ptts_pkg::MAX_OUT - 1));
  end

  always_comb begin
    o_kind = ptts_pkg::RK_IDLE;
    o_num  = '0;
    o_en   = 1'b0;
    o_call = 1'b0;
    case (cmd.emit_sel)
      ptts_pkg::EM_REJ: begin
        o_kind = ptts_pkg::RK_REJECTED;
      end
      ptts_pkg::EM_REG: begin
        o_kind = ptts_pkg::RK_REGISTERED;
        o_num  = 4'(count);
        o_en   = on;
      end
      ptts_pkg::EM_TOG: begin
        o_kind = ptts_pkg::RK_TOGGLED;
        o_num  = id;
        o_en   = ~en_rd;
      end
      ptts_pkg::EM_REP: begin
        o_kind = ptts_pkg::RK_REPORT;
        o_num  = 4'(ann_idx);
        o_en   = en_rd;
      end
      ptts_pkg::EM_PEND: begin
        o_kind = ptts_pkg::RK_FIRED;
        o_num  = pend_num;
        o_en   = pend_en;
        o_call = pend_en;
      end
      default: begin
        o_kind = ptts_pkg::RK_IDLE;
      end
    endcase
  end

  // payload and table registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ival <= interval_ms;
      on   <= start_on;
      id   <= task_id;
      now  <= now_ms;
    end
    if (cmd.reg_write) begin
      en[cnt_idx] <= on;
    end
    if (cmd.tog_write) begin
      en[id_idx] <= ~en_rd;
    end
    if (cmd.ann_start) begin
      ann_idx <= '0;
    end else if (cmd.ann_step) begin
      ann_idx <= ann_idx + TW'(1);
    end
    if (cmd.tick_start) begin
      done <= '0;
    end else if (cmd.fire_b) begin
      done[best] <= 1'b1;
    end
    if (cmd.scan_run && !cmd.scan_start) begin
      cmp_idx <= issue[TW-1:0];
      if (cmp_valid && !done[cmp_idx] && dl_rdata <= now &&
          (!found || dl_rdata < best_dl)) begin
        best    <= cmp_idx;
        best_dl <= dl_rdata;
      end
    end
    if (cmd.fire_a) begin
      nx1 <= ptts_pkg::sat_add(best_dl, ptts_pkg::TIME_W'(iv_rdata));
      alt <= ptts_pkg::sat_add(now, ptts_pkg::TIME_W'(iv_rdata));
    end
    if (cmd.fire_b) begin
      pend_num <= 4'(best);
      pend_en  <= en_rd;
    end
    if (cmd.emit) begin
      result_kind   <= o_kind;
      task_number   <= o_num;
      enabled       <= o_en;
      call_periodic <= o_call;
      last          <= cmd.emit_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      issue      <= '0;
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      fired      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.reg_write) begin
        count <= count + CW'(1);
      end
      if (cmd.scan_start) begin
        issue     <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan_run) begin
        if (issue < count) begin
          issue     <= issue + CW'(1);
          cmp_valid <= 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
        if (cmp_valid && !done[cmp_idx] && dl_rdata <= now &&
            (!found || dl_rdata < best_dl)) begin
          found <= 1'b1;
        end
      end
      if (cmd.tick_start) begin
        fired      <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.fire_b) begin
        fired      <= fired + FW'(1);
        pend_valid <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: design/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Controller: sequences register, toggle, tick and announce items.
// ----------------------------------------------------------------------------
module ptts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_ready,
  input  ptts_pkg::ptts_stat_t stat,
  output ptts_pkg::ptts_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REG    = 4'd1;
  localparam logic [3:0] S_TOG    = 4'd2;
  localparam logic [3:0] S_ANN    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_FIRE_A = 4'd6;
  localparam logic [3:0] S_FIRE_B = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = ptts_pkg::EM_IDLE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_kind)
            ptts_pkg::KIND_REG: state_next = S_REG;
            ptts_pkg::KIND_TOG: state_next = S_TOG;
            ptts_pkg::KIND_TICK: begin
              cmd.tick_start = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            default: begin
              cmd.ann_start = 1'b1;
              state_next    = S_ANN;
            end
          endcase
        end
      end
      S_REG: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_sel  = stat.full ? ptts_pkg::EM_REJ : ptts_pkg::EM_REG;
          cmd.reg_write = !stat.full;
          state_next    = S_IDLE;
        end
      end
      S_TOG: begin
        cmd.emit_sel = stat.tog_bad ? ptts_pkg::EM_REJ : ptts_pkg::EM_TOG;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.tog_write = !stat.tog_bad;
          state_next    = S_IDLE;
        end
      end
      S_ANN: begin
        if (stat.cnt_zero) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.emit_sel = ptts_pkg::EM_REP;
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = stat.ann_last;
            cmd.ann_step  = 1'b1;
            if (stat.ann_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.found) begin
          if (!stat.pend_valid) begin
            state_next = S_FIRE_A;
          end else if (stat.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = ptts_pkg::EM_PEND;
            state_next   = S_FIRE_A;
          end
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_sel  = stat.pend_valid ? ptts_pkg::EM_PEND : ptts_pkg::EM_IDLE;
          state_next    = S_IDLE;
        end
      end
      S_FIRE_A: begin
        cmd.fire_a = 1'b1;
        state_next = S_FIRE_B;
      end
      S_FIRE_B: begin
        cmd.fire_b = 1'b1;
        if (stat.fire_full) begin
          state_next = S_FLUSH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_FLUSH: begin
        cmd.emit_sel = ptts_pkg::EM_PEND;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// File: design/periodic_task_timer_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_scheduler_unit
// Table of periodic tasks: register, toggle, tick (fire due tasks in deadline
// order) and announce items, each answered by one or more result beats.
//
//   channel  role    beat
//   req      sink    one item: kind, interval_ms, start_on, task_id, now_ms
//   rsp      source  one result: result_kind, task_number, enabled,
//                    call_periodic, last
//
// Register and toggle answer with one beat; announce with one beat per task
// (an idle beat when empty). Tick: each fired task costs a deadline scan and
// an update in states FIRE_A and FIRE_B; a final scan finds nothing, or 16
// fires end in a flush state.
// Reset (rst, synchronous) empties the table; task entries need no clearing.
// A stalled rsp holds the controller; req is taken again once an item is done.
// ----------------------------------------------------------------------------
module periodic_task_timer_scheduler_unit (
  input  logic       clk,
  input  logic       rst,
  ptts_req_if.sink   req,
  ptts_rsp_if.source rsp
);
  ptts_pkg::ptts_cmd_t  cmd;
  ptts_pkg::ptts_stat_t stat;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .interval_ms   (req.interval_ms),
    .start_on      (req.start_on),
    .task_id       (req.task_id),
    .now_ms        (req.now_ms),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .result_kind   (rsp.result_kind),
    .task_number   (rsp.task_number),
    .enabled       (rsp.enabled),
    .call_periodic (rsp.call_periodic),
    .last          (rsp.last)
  );
endmodule
